@@ hdl/gf2_poly_block_xor_division_assert.svh @@
// assertion macros for the block-xor division block
// used by the top level; expects clk and rst in scope
`ifndef GF2_POLY_BLOCK_XOR_DIVISION_ASSERT_SVH
`define GF2_POLY_BLOCK_XOR_DIVISION_ASSERT_SVH

// consequent holds in the same cycle
`define GPBXD_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define GPBXD_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`define GPBXD_CHECK_DLY2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

@@ hdl/gpbxd_pkg.sv @@
// shared types and constants for the block-xor division block
// no dependencies
package gpbxd_pkg;

  // store depth default and fixed field widths
  localparam int DEPTH_DEFAULT = 1024;
  localparam int LEN_W         = 11;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 11;

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_BLOCK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLY_LENGTH  = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_RESP,
    ST_RUN_RD,
    ST_RUN_WR
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       host_wr;
    logic       host_rd;
    logic       run_init;
    logic       step;
    logic       out_load;
    logic       out_from_mem;
    logic [1:0] out_kind;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic run_empty;
    logic run_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ hdl/gpbxd_datapath.sv @@
// coefficient memory, block walk counters and result register
// depends on gpbxd_pkg
module gpbxd_datapath #(
  parameter int DEPTH = gpbxd_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gpbxd_pkg::ctrl_cmd_t                cmd,
  output gpbxd_pkg::dp_status_t               status,
  input  logic [3:0]                          log_block,
  input  logic                                inverse_mode,
  input  logic [gpbxd_pkg::LEN_W-1:0]         poly_length,
  input  logic [9:0]                          word_index,
  input  logic [63:0]                         word_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [63:0]                         read_data,
  output logic [1:0]                          done_kind
);
  import gpbxd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [63:0]      mem [DEPTH];
  logic [63:0]      rd_a;
  logic [63:0]      rd_b;
  logic [AW-1:0]    rd_a_addr;
  logic [AW-1:0]    rd_b_addr;
  logic [AW-1:0]    wr_addr;
  logic [63:0]      wr_data;
  logic             wr_en;
  logic [AW-1:0]    host_addr;
  logic             in_range;
  logic             rd_zero;

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] nblk;
  logic [LEN_W-1:0] bmask;
  logic [LEN_W-1:0] start_i;
  logic [LEN_W-1:0] next_i;
  logic [LEN_W-1:0] i_cnt;
  logic [LEN_W-1:0] k_cnt;
  logic [LEN_W-1:0] j_cnt;
  logic [LEN_W-1:0] src_lin;
  logic [LEN_W-1:0] dst_lin;
  logic             j_last;
  logic             k_last;
  logic             i_last;

  // run geometry from the configuration
  always_comb begin
    len     = (32'(poly_length) > DEPTH) ? LEN_W'(DEPTH) : poly_length;
    nblk    = len >> log_block;
    bmask   = LEN_W'((32'd1 << log_block) - 32'd1);
    start_i = inverse_mode ? LEN_W'(2) : ((nblk - LEN_W'(1)) & ~LEN_W'(1));
    next_i  = inverse_mode ? (i_cnt + LEN_W'(2)) : (i_cnt - LEN_W'(2));
    j_last  = (j_cnt == bmask);
    // k stays below the lowest set bit of i
    k_last  = ((i_cnt & (k_cnt << 1)) != '0);
    i_last  = inverse_mode ?
              (({1'b0, i_cnt} + (LEN_W+1)'(2)) >= {1'b0, nblk}) :
              (i_cnt == LEN_W'(2));
    src_lin = (i_cnt << log_block) + j_cnt;
    dst_lin = ((i_cnt - k_cnt) << log_block) + j_cnt;
  end

  // walk counters: word j, then power k, then block i
  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      i_cnt <= start_i;
      k_cnt <= LEN_W'(1);
      j_cnt <= '0;
    end else if (cmd.step) begin
      if (!j_last) begin
        j_cnt <= j_cnt + LEN_W'(1);
      end else begin
        j_cnt <= '0;
        if (!k_last) begin
          k_cnt <= k_cnt << 1;
        end else begin
          k_cnt <= LEN_W'(1);
          i_cnt <= next_i;
        end
      end
    end
  end

  // memory ports
  always_comb begin
    host_addr = AW'(word_index);
    in_range  = (32'(word_index) < DEPTH);
    rd_a_addr = cmd.host_rd ? host_addr : AW'(src_lin);
    rd_b_addr = AW'(dst_lin);
    wr_en     = (cmd.host_wr && in_range) || cmd.step;
    wr_addr   = cmd.host_wr ? host_addr : AW'(dst_lin);
    wr_data   = cmd.host_wr ? word_value : (rd_a ^ rd_b);
  end

  always_ff @(posedge clk) begin
    rd_a <= mem[rd_a_addr];
    rd_b <= mem[rd_b_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // out of range reads answer zero
  always_ff @(posedge clk) begin
    if (cmd.host_rd) begin
      rd_zero <= !in_range;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_data <= (cmd.out_from_mem && !rd_zero) ? rd_a : '0;
      done_kind <= cmd.out_kind;
    end
  end

  // status back to the controller
  always_comb begin
    status.run_empty = (nblk < LEN_W'(3));
    status.run_last  = j_last && k_last && i_last;
    status.out_free  = !out_valid || out_ready;
  end

endmodule

@@ hdl/gpbxd_ctrl.sv @@
// controller state machine: sequences host ops and the transform walk
// depends on gpbxd_pkg
module gpbxd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            op,
  input  gpbxd_pkg::dp_status_t status,
  output gpbxd_pkg::ctrl_cmd_t  cmd
);
  import gpbxd_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    accept     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = status.out_free;
        accept   = in_valid && status.out_free;
        if (accept) begin
          case (op)
            OP_WRITE: begin
              cmd.host_wr  = 1'b1;
              cmd.out_load = 1'b1;
              cmd.out_kind = OP_WRITE;
            end
            OP_RUN: begin
              cmd.run_init = 1'b1;
              if (status.run_empty) begin
                cmd.out_load = 1'b1;
                cmd.out_kind = OP_RUN;
              end else begin
                state_next = ST_RUN_RD;
              end
            end
            OP_READ: begin
              cmd.host_rd = 1'b1;
              state_next  = ST_READ_RESP;
            end
            default: ;
          endcase
        end
      end
      ST_READ_RESP: begin
        cmd.out_load     = 1'b1;
        cmd.out_from_mem = 1'b1;
        cmd.out_kind     = OP_READ;
        state_next       = ST_IDLE;
      end
      // fetch source and destination words
      ST_RUN_RD: begin
        state_next = ST_RUN_WR;
      end
      // write back the xor and advance the walk
      ST_RUN_WR: begin
        cmd.step = 1'b1;
        if (status.run_last) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = OP_RUN;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_RUN_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/gf2_poly_block_xor_division.sv @@
// top level of the binary-field block-xor division block
// depends on gpbxd_pkg, gpbxd_ctrl, gpbxd_datapath and the assertion header
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word: op, word_index,
//   word_value. op 0 writes word_value at word_index, op 2 reads the word
//   at word_index, op 1 runs the block-xor transform over the store, and
//   op 3 is taken and dropped without a result.
//   Output channel (out_valid/out_ready) returns one word per op 0-2:
//   read_data (stored word on read, else zero) and done_kind (the op echoed).
//   Configuration channel (cfg_valid/cfg_ready) writes log_block (index 0),
//   inverse_mode (index 1) and poly_length (index 2); it is always ready.
//   A write result shows in the cycle after acceptance; a read result
//   first passes through the read-response state. A run steps through
//   the words of the even blocks i, each a read pair, then the xor written
//   back through the single write port of the coefficient memory. A run
//   with under three whole blocks answers in the cycle after acceptance.
//   Reset clears configuration and control; the memory is not cleared and
//   its words are undefined until written.
//   A stalled result holds in the output register; the next word is taken
//   in the cycle the result slot frees.
module gf2_poly_block_xor_division #(
  parameter int DEPTH = gpbxd_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           op,
  input  logic [9:0]                           word_index,
  input  logic [63:0]                          word_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [63:0]                          read_data,
  output logic [1:0]                           done_kind,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gpbxd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gpbxd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import gpbxd_pkg::*;

  `include "gf2_poly_block_xor_division_assert.svh"

  logic [3:0]       log_block;
  logic             inverse_mode;
  logic [LEN_W-1:0] poly_length;
  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic             in_accept;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_block    <= '0;
      inverse_mode <= 1'b0;
      poly_length  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOG_BLOCK:    log_block    <= cfg_data[3:0];
        CFG_INVERSE_MODE: inverse_mode <= cfg_data[0];
        CFG_POLY_LENGTH:  poly_length  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  gpbxd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .status   (status),
    .cmd      (cmd)
  );

  gpbxd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .log_block    (log_block),
    .inverse_mode (inverse_mode),
    .poly_length  (poly_length),
    .word_index   (word_index),
    .word_value   (word_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .done_kind    (done_kind)
  );

  assign in_accept = in_valid && in_ready;

  // checks
  `GPBXD_CHECK_NOW(a_slot_free, in_accept, !out_valid || out_ready, "accept with result slot busy")
  `GPBXD_CHECK_NEXT(a_write_result, in_accept && op == OP_WRITE, out_valid && done_kind == OP_WRITE, "write result missing")
  `GPBXD_CHECK_DLY2(a_read_result, in_accept && op == OP_READ, out_valid && done_kind == OP_READ, "read result late")
  `GPBXD_CHECK_NOW(a_zero_data, out_valid && done_kind != OP_READ, read_data == '0, "nonzero data on non-read")

endmodule
